// ===== rtl/wsat_pkg.sv =====
// Shared types and constants for the station association tracker.
`default_nettype none
package wsat_pkg;
  localparam int MAC_W = 48;
  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_BEACON  = 3'd1;
  localparam logic [2:0] ST_PROBE   = 3'd2;
  localparam logic [2:0] ST_PAIR    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;
  localparam logic [1:0] TYPE_MGMT = 2'd0;
  localparam logic [1:0] TYPE_DATA = 2'd2;
  localparam logic [3:0] SUB_BEACON = 4'd8;
  localparam logic [3:0] SUB_PROBE  = 4'd4;
  localparam logic [1:0] DS_TO   = 2'd1;
  localparam logic [1:0] DS_FROM = 2'd2;
  localparam int GROUP_BIT = 40;
  localparam logic [6:0] TOTAL_MAX = 7'd127;
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam logic REG_FOCUS  = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  function automatic logic bad_mac(input logic [MAC_W-1:0] m);
    return m[GROUP_BIT] || (m == '0);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/wsat_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module wsat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/wlan_station_association_tracker_core.sv =====
// Top level of the station association tracker.
// Usage: frame headers arrive on the in_ channel (valid/ready), one item
// at a time; every item yields one result item on the out_ channel.
// An item is taken only while the block is idle. The sequencer then
// searches the AP table, one entry a cycle, then the client table, one
// entry a cycle, each only where the frame needs it, then writes back
// any counters that moved and finally searches the AP table again to
// report the target's client total. Each table is a single-port memory.
// The result waits in an output register; while out_ready is low the
// block holds it and takes no new item.
// Reset (rst_n low, synchronous) empties both tables through the fill
// counts and clears both registers; no clearing pass is needed since no
// entry beyond a fill count is ever read. A clear op empties the tables
// the same way.
// Configuration is an APB-style port; focus_mode at 0x0, target_bssid
// (low 48 bits of the 64-bit data) at 0x8.
`default_nettype none
module wlan_station_association_tracker_core #(
  parameter int AP_SLOTS     = 32,
  parameter int CLIENT_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [1:0]  in_frame_type,
  input  wire logic [3:0]  in_frame_subtype,
  input  wire logic [1:0]  in_ds_bits,
  input  wire logic [47:0] in_address_one,
  input  wire logic [47:0] in_address_two,
  input  wire logic [47:0] in_address_three,
  input  wire logic        in_has_second,
  input  wire logic        in_has_third,
  input  wire logic [7:0]  in_radio_channel,
  input  wire logic signed [7:0] in_signal_dbm,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic signed [5:0] out_ap_index,
  output logic signed [6:0] out_client_index,
  output logic [5:0]       out_ap_count,
  output logic [6:0]       out_client_count,
  output logic [6:0]       out_target_clients,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int AW  = (AP_SLOTS > 1) ? $clog2(AP_SLOTS) : 1;
  localparam int CW  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int AFW = $clog2(AP_SLOTS + 1);
  localparam int CFW = $clog2(CLIENT_SLOTS + 1);
  // AP entry: mac, chan, signal, seen, total
  localparam int APW = 48 + 8 + 8 + 32 + 7;
  // client entry: mac, assoc, slot, chan, signal, seen, packets
  localparam int CLW = 48 + 1 + AW + 8 + 8 + 32 + 32;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_ASRCH  = 4'd2;
  localparam logic [3:0] S_CSRCH  = 4'd3;
  localparam logic [3:0] S_CUPD   = 4'd4;
  localparam logic [3:0] S_ORD    = 4'd5;  // read old AP entry
  localparam logic [3:0] S_OWR    = 4'd6;  // decrement old AP total
  localparam logic [3:0] S_NRD    = 4'd7;  // read new AP entry
  localparam logic [3:0] S_NWR    = 4'd8;  // increment new AP total
  localparam logic [3:0] S_TSRCH  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_r, state_nxt;

  // configuration
  localparam logic REG_FOCUS_ADDR = wsat_pkg::REG_FOCUS;
  logic        focus_r;
  logic [47:0] target_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focus_r  <= 1'b0;
      target_r <= '0;
    end else if (cfg_wr && cfg_paddr[2:0] == 3'd0) begin
      if (cfg_paddr[3] == REG_FOCUS_ADDR) focus_r <= cfg_pwdata[0];
      else target_r <= cfg_pwdata[47:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == 4'd0) cfg_prdata[0] = focus_r;
    else if (cfg_paddr == 4'd8) cfg_prdata[47:0] = target_r;
  end

  // captured item
  logic        op_r;
  logic [1:0]  type_r, ds_r;
  logic [3:0]  sub_r;
  logic [47:0] a1_r, a2_r, a3_r;
  logic        has2_r, has3_r;
  logic [7:0]  ch_r, sig_r;
  logic [31:0] now_r;

  // decoded job
  logic        do_ap_r, do_cl_r;
  logic [47:0] apm_r, clm_r;
  logic [2:0]  st_r;

  logic [AFW-1:0] ap_fill_r;
  logic [CFW-1:0] cl_fill_r;
  logic [AFW-1:0] idx_r;   // AP scan position
  logic [CFW-1:0] cidx_r;  // client scan position
  logic           api_ok_r;
  logic [AW-1:0]  api_r;
  logic           cli_ok_r;
  logic [CW-1:0]  cli_r;
  logic [AW-1:0]  old_slot_r;
  logic [6:0]     tgt_r;

  // memories
  logic           ap_we, cl_we;
  logic [AW-1:0]  ap_addr;
  logic [CW-1:0]  cl_addr;
  logic [APW-1:0] ap_wd, ap_rd;
  logic [CLW-1:0] cl_wd, cl_rd;
  logic           rd_pend_r;  // read data valid this cycle for idx_r-1 or cidx_r-1

  wsat_ram #(.WIDTH(APW), .DEPTH(AP_SLOTS)) u_ap_ram (
    .clk(clk), .we(ap_we), .addr(ap_addr), .wdata(ap_wd), .rdata(ap_rd));
  wsat_ram #(.WIDTH(CLW), .DEPTH(CLIENT_SLOTS)) u_cl_ram (
    .clk(clk), .we(cl_we), .addr(cl_addr), .wdata(cl_wd), .rdata(cl_rd));

  logic [47:0] ap_rd_mac;
  logic [6:0]  ap_rd_tot;
  assign ap_rd_mac = ap_rd[APW-1 -: 48];
  assign ap_rd_tot = ap_rd[6:0];
  logic [47:0] cl_rd_mac;
  logic        cl_rd_assoc;
  logic [AW-1:0] cl_rd_slot;
  logic [31:0] cl_rd_pk;
  assign cl_rd_mac   = cl_rd[CLW-1 -: 48];
  assign cl_rd_assoc = cl_rd[CLW-49];
  assign cl_rd_slot  = cl_rd[CLW-50 -: AW];
  assign cl_rd_pk    = cl_rd[31:0];

  logic [AFW-1:0] prev_idx;
  logic [CFW-1:0] prev_cidx;
  assign prev_idx  = idx_r - AFW'(1);
  assign prev_cidx = cidx_r - CFW'(1);

  logic out_valid_r;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;

  logic [2:0]  ost_r;
  logic signed [5:0] oapi_r;
  logic signed [6:0] ocli_r;
  logic [6:0]  otgt_r;
  assign out_status       = ost_r;
  assign out_ap_index     = oapi_r;
  assign out_client_index = ocli_r;
  assign out_ap_count     = 6'(ap_fill_r);
  assign out_client_count = 7'(cl_fill_r);
  assign out_target_clients = otgt_r;

  // decode combinational
  logic        d_pair_ok, d_beacon, d_probe;
  logic [47:0] d_apm, d_clm;
  always_comb begin
    d_apm = (ds_r == wsat_pkg::DS_FROM) ? a2_r : a1_r;
    d_clm = (ds_r == wsat_pkg::DS_FROM) ? a1_r : a2_r;
    d_pair_ok = (type_r == wsat_pkg::TYPE_DATA)
      && (ds_r == wsat_pkg::DS_FROM || ds_r == wsat_pkg::DS_TO)
      && !wsat_pkg::bad_mac(d_clm) && !wsat_pkg::bad_mac(d_apm)
      && !(focus_r && d_apm != target_r);
    d_beacon = !focus_r && type_r == wsat_pkg::TYPE_MGMT
      && sub_r == wsat_pkg::SUB_BEACON && has3_r;
    d_probe = !focus_r && type_r == wsat_pkg::TYPE_MGMT
      && sub_r == wsat_pkg::SUB_PROBE && has2_r && !wsat_pkg::bad_mac(a2_r);
  end

  logic ap_hit, cl_hit;
  assign ap_hit = rd_pend_r && (ap_rd_mac == apm_r);
  assign cl_hit = rd_pend_r && (cl_rd_mac == clm_r);

  logic         new_assoc;
  assign new_assoc = api_ok_r && (!cl_rd_assoc || cl_rd_slot != api_r);

  always_comb begin
    ap_we = 1'b0; cl_we = 1'b0;
    ap_addr = AW'(idx_r); cl_addr = CW'(cidx_r);
    ap_wd = {apm_r, ch_r, sig_r, now_r, 7'd0};
    cl_wd = {clm_r, api_ok_r, api_ok_r ? api_r : AW'(0), ch_r, sig_r, now_r, 32'd1};
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = S_DEC;
      S_DEC: begin
        // the decoded job is registered at this edge, so steer on the decode itself
        if (op_r == wsat_pkg::OP_CLEAR) state_nxt = S_TSRCH;
        else if (d_pair_ok || d_beacon) state_nxt = S_ASRCH;
        else if (d_probe) state_nxt = S_CSRCH;
        else state_nxt = S_TSRCH;
      end
      S_ASRCH: begin
        if (ap_hit) begin
          ap_we = 1'b1; ap_addr = AW'(prev_idx);
          ap_wd = {apm_r, ch_r, sig_r, now_r, ap_rd_tot};
          state_nxt = do_cl_r ? S_CSRCH : S_TSRCH;
        end else if (idx_r >= ap_fill_r && !(rd_pend_r == 1'b0 && idx_r != '0)) begin
          if (ap_fill_r < AFW'(AP_SLOTS)) begin
            ap_we = 1'b1; ap_addr = AW'(ap_fill_r);
          end
          state_nxt = do_cl_r ? S_CSRCH : S_TSRCH;
        end
      end
      S_CSRCH: begin
        if (cl_hit) begin
          cl_addr = CW'(prev_cidx);
          state_nxt = S_CUPD;
        end else if (cidx_r >= cl_fill_r && !(rd_pend_r == 1'b0 && cidx_r != '0)) begin
          if (cl_fill_r < CFW'(CLIENT_SLOTS)) begin
            cl_we = 1'b1; cl_addr = CW'(cl_fill_r);
          end
          state_nxt = (cl_fill_r < CFW'(CLIENT_SLOTS) && api_ok_r) ? S_NRD : S_TSRCH;
        end
      end
      S_CUPD: begin
        cl_we = 1'b1; cl_addr = cli_r;
        cl_wd = {clm_r, new_assoc ? 1'b1 : cl_rd_assoc,
                 new_assoc ? api_r : cl_rd_slot, ch_r, sig_r, now_r, cl_rd_pk + 32'd1};
        if (new_assoc && cl_rd_assoc && AFW'(cl_rd_slot) < ap_fill_r) state_nxt = S_ORD;
        else if (new_assoc) state_nxt = S_NRD;
        else state_nxt = S_TSRCH;
      end
      S_ORD: begin ap_addr = old_slot_r; state_nxt = S_OWR; end
      S_OWR: begin
        ap_addr = old_slot_r; ap_we = 1'b1;
        ap_wd = {ap_rd[APW-1:7], (ap_rd_tot != 7'd0) ? ap_rd_tot - 7'd1 : 7'd0};
        state_nxt = S_NRD;
      end
      S_NRD: begin ap_addr = api_r; state_nxt = S_NWR; end
      S_NWR: begin
        ap_addr = api_r; ap_we = 1'b1;
        ap_wd = {ap_rd[APW-1:7],
                 (ap_rd_tot < wsat_pkg::TOTAL_MAX) ? ap_rd_tot + 7'd1 : ap_rd_tot};
        state_nxt = S_TSRCH;
      end
      S_TSRCH: begin
        if (rd_pend_r && ap_rd_mac == target_r) state_nxt = S_OUT;
        else if (idx_r >= ap_fill_r && !(rd_pend_r == 1'b0 && idx_r != '0))
          state_nxt = S_OUT;
      end
      S_OUT: if (!out_valid_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // capture and sequencing registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_op; type_r <= in_frame_type; sub_r <= in_frame_subtype;
      ds_r <= in_ds_bits; a1_r <= in_address_one; a2_r <= in_address_two;
      a3_r <= in_address_three; has2_r <= in_has_second; has3_r <= in_has_third;
      ch_r <= in_radio_channel; sig_r <= in_signal_dbm; now_r <= in_now_ms;
    end
    if (state_r == S_DEC) begin
      do_ap_r <= d_pair_ok || d_beacon;
      do_cl_r <= d_pair_ok || d_probe;
      apm_r   <= d_beacon ? a3_r : d_apm;
      clm_r   <= d_probe ? a2_r : d_clm;
      st_r    <= d_pair_ok ? wsat_pkg::ST_PAIR : d_beacon ? wsat_pkg::ST_BEACON :
                 d_probe ? wsat_pkg::ST_PROBE : wsat_pkg::ST_IGNORED;
      api_ok_r <= 1'b0; cli_ok_r <= 1'b0; tgt_r <= 7'd0;
    end
    if (state_r == S_ASRCH) begin
      if (ap_hit) begin api_ok_r <= 1'b1; api_r <= AW'(prev_idx); end
      else if (state_nxt != S_ASRCH && ap_fill_r < AFW'(AP_SLOTS)) begin
        api_ok_r <= 1'b1; api_r <= AW'(ap_fill_r);
      end
    end
    if (state_r == S_CSRCH) begin
      if (cl_hit) begin cli_ok_r <= 1'b1; cli_r <= CW'(prev_cidx); end
      else if (state_nxt != S_CSRCH && cl_fill_r < CFW'(CLIENT_SLOTS)) begin
        cli_ok_r <= 1'b1; cli_r <= CW'(cl_fill_r);
      end
    end
    if (state_r == S_CUPD) old_slot_r <= cl_rd_slot;
    if (state_r == S_TSRCH && rd_pend_r && ap_rd_mac == target_r) tgt_r <= ap_rd_tot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
      ap_fill_r <= '0; cl_fill_r <= '0;
      idx_r <= '0; cidx_r <= '0; rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // scan counters: issue address idx, read data valid in the following cycle
      if (state_nxt != state_r || state_r == S_DEC) begin
        idx_r <= '0; cidx_r <= '0; rd_pend_r <= 1'b0;
      end else if (state_r == S_ASRCH || state_r == S_TSRCH) begin
        if (idx_r < ap_fill_r) begin
          idx_r <= idx_r + AFW'(1); rd_pend_r <= 1'b1;
        end else rd_pend_r <= 1'b0;
      end else if (state_r == S_CSRCH) begin
        if (cidx_r < cl_fill_r) begin
          cidx_r <= cidx_r + CFW'(1); rd_pend_r <= 1'b1;
        end else rd_pend_r <= 1'b0;
      end
      if (state_r == S_DEC && op_r == wsat_pkg::OP_CLEAR) begin
        ap_fill_r <= '0; cl_fill_r <= '0;
      end
      if (state_r == S_ASRCH && state_nxt != S_ASRCH && !ap_hit
          && ap_fill_r < AFW'(AP_SLOTS)) ap_fill_r <= ap_fill_r + AFW'(1);
      if (state_r == S_CSRCH && state_nxt != S_CSRCH && !cl_hit
          && cl_fill_r < CFW'(CLIENT_SLOTS)) cl_fill_r <= cl_fill_r + CFW'(1);
      if (state_r == S_OUT && !out_valid_r) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && !out_valid_r) begin
      ost_r  <= (op_r == wsat_pkg::OP_CLEAR) ? wsat_pkg::ST_CLEARED : st_r;
      oapi_r <= (op_r != wsat_pkg::OP_CLEAR && do_ap_r && api_ok_r) ? 6'(api_r) : -6'sd1;
      ocli_r <= (op_r != wsat_pkg::OP_CLEAR && do_cl_r && cli_ok_r) ? 7'(cli_r) : -7'sd1;
      otgt_r <= tgt_r;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/wsat_checker.sv =====
// Port-level checker for the tracker, bound to the top level.
`default_nettype none
module wsat_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic [5:0] out_ap_count,
  input wire logic [6:0] out_client_count
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("item taken while result pending");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == wsat_pkg::ST_CLEARED |->
    out_ap_count == 6'd0 && out_client_count == 7'd0)
    else $error("clear left entries");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= wsat_pkg::ST_CLEARED) else $error("bad status");
endmodule
bind wlan_station_association_tracker_core wsat_checker u_wsat_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_ap_count(out_ap_count), .out_client_count(out_client_count));
`default_nettype wire
